/* src/path_crosses_finish_line_top_assert.svh */
// Assertion macros for the finish line crossing detector.
// Used by the checker module; it expects a signal named clock in scope.
`ifndef PATH_CROSSES_FINISH_LINE_TOP_ASSERT_SVH
`define PATH_CROSSES_FINISH_LINE_TOP_ASSERT_SVH

// Overlapping implication, checked at every rising clock edge.
`define PCFL_ASSERT_NOW(label, dis, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// Non-overlapping implication: the consequent is checked in the cycle after the antecedent.
`define PCFL_ASSERT_NEXT(label, dis, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/pcfl_pkg.sv */
// Package for the finish line crossing detector.
// Holds widths, register indexes, reset values and the shared token and CSR types.
package pcfl_pkg;

   localparam int COORD_W     = 16;
   localparam int STAMP_W     = 64;
   localparam int HIT_W       = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int TAPE_REGS   = 4;
   localparam int NUM_TAPES_DEFAULT = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_TAPE0  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPE1  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPE2  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPE3  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE = 3'd4;

   localparam logic [CSR_DATA_W-1:0] TAPE_RESET [TAPE_REGS] = '{
      64'h0100_0000_0000_0000, 64'h0, 64'h0, 64'h0
   };
   localparam logic [TAPE_REGS-1:0] ENABLE_RESET = 4'b0001;

   typedef struct packed {
      logic                        we;
      logic [CSR_INDEX_W-1:0]      index;
      logic [CSR_DATA_W-1:0]       wdata;
   } pcfl_csr_type;

   typedef struct packed {
      logic                        valid;
      logic signed [COORD_W-1:0]   ax;
      logic signed [COORD_W-1:0]   ay;
      logic signed [COORD_W-1:0]   bx;
      logic signed [COORD_W-1:0]   by;
      logic [STAMP_W-1:0]          stamp;
      logic                        found;
      logic [HIT_W-1:0]            hit;
   } pcfl_token_type;

endpackage

/* src/pcfl_if.sv */
// Valid/ready channel interfaces for sample requests and crossing responses.
// Depends on pcfl_pkg for field widths.
interface pcfl_req_if import pcfl_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic [STAMP_W-1:0]        stamp_ns;

   modport source (output valid, pos_x, pos_y, stamp_ns, input ready);
   modport sink   (input valid, pos_x, pos_y, stamp_ns, output ready);
endinterface

interface pcfl_rsp_if import pcfl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [HIT_W-1:0]   tape_hit;
   logic [STAMP_W-1:0] cross_time;

   modport source (output valid, tape_hit, cross_time, input ready);
   modport sink   (input valid, tape_hit, cross_time, output ready);
endinterface

/* src/path_crosses_finish_line_top.sv */
// Top level of the finish line crossing detector: sample channel, response
// channel, CSR write port and the chain of tape cells. Depends on pcfl_pkg,
// pcfl_if and pcfl_cell.
//
// Usage: each request transaction carries a Q8.8 position and a timestamp.
// The first sample after reset is only stored and gives no response. Every
// later sample forms a segment from the stored position; a token carrying it
// walks the cell chain, where each cell registers products, then sign tests,
// and the first enabled tape hit in tape order marks the token. A marked token
// becomes one response transaction with the tape index and the timestamp; an
// unmarked token produces nothing.
// Only one sample is in flight at a time: after a segment is accepted, no
// new sample is taken until its token leaves the chain of N = min(NUM_TAPES, 4)
// cells. A first sample does not hold off the next one.
// The response sits in an output register, so a new request is accepted while
// a response waits. If the receiver stalls and the next marked token reaches
// the end of the chain, the chain holds until the output register frees.
// Reset clears the stored position, the chain tokens and the output valid
// flag, and loads the default tapes and enable mask. CSR writes are to be
// made only while idle, by the user; the block itself does not enforce this.
module path_crosses_finish_line_top import pcfl_pkg::*; #(
   parameter int NUM_TAPES = NUM_TAPES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   pcfl_req_if.sink               req_chan,
   pcfl_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NUM_CELLS = (NUM_TAPES < TAPE_REGS) ? NUM_TAPES : TAPE_REGS;

   pcfl_csr_type   csr;
   pcfl_token_type tok [NUM_CELLS+1];
   pcfl_token_type fin;

   logic signed [COORD_W-1:0] prev_x_ff, prev_x_in;
   logic signed [COORD_W-1:0] prev_y_ff, prev_y_in;
   logic                      have_prev_ff, have_prev_in;
   logic                      busy_ff, busy_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [HIT_W-1:0]          rsp_hit_ff, rsp_hit_in;
   logic [STAMP_W-1:0]        rsp_time_ff, rsp_time_in;
   logic                      accept, consume, advance;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   assign req_chan.ready = !busy_ff;
   assign accept         = req_chan.valid && !busy_ff;

   assign fin     = tok[NUM_CELLS];
   assign consume = fin.valid && (!fin.found || !rsp_valid_ff || rsp_chan.ready);
   assign advance = !fin.valid || consume;

   always_comb begin
      tok[0].valid = accept && have_prev_ff;
      tok[0].ax    = prev_x_ff;
      tok[0].ay    = prev_y_ff;
      tok[0].bx    = req_chan.pos_x;
      tok[0].by    = req_chan.pos_y;
      tok[0].stamp = req_chan.stamp_ns;
      tok[0].found = 1'b0;
      tok[0].hit   = '0;
   end

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      pcfl_cell #(.INDEX(i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .csr     (csr),
         .tok_i   (tok[i]),
         .tok_o   (tok[i+1])
      );
   end

   always_comb begin
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      have_prev_in = have_prev_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_time_in  = rsp_time_ff;
      if (accept) begin
         prev_x_in    = req_chan.pos_x;
         prev_y_in    = req_chan.pos_y;
         have_prev_in = 1'b1;
         busy_in      = have_prev_ff;
      end
      if (consume) begin
         busy_in = 1'b0;
      end
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (consume && fin.found) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = fin.hit;
         rsp_time_in  = fin.stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         have_prev_ff <= have_prev_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff  <= rsp_hit_in;
      rsp_time_ff <= rsp_time_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.tape_hit   = rsp_hit_ff;
   assign rsp_chan.cross_time = rsp_time_ff;

endmodule

/* src/pcfl_cell.sv */
// One tape cell: holds a tape and its enable bit and tests the passing segment.
// Two register stages: cross products, then sign tests. Depends on pcfl_pkg.
module pcfl_cell import pcfl_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  pcfl_csr_type   csr,
   input  pcfl_token_type tok_i,
   output pcfl_token_type tok_o
);

   localparam logic [CSR_INDEX_W-1:0] MY_INDEX = CSR_INDEX_W'(CSR_TAPE0 + INDEX);

   logic [CSR_DATA_W-1:0]      tape_ff;
   logic                       enable_ff;
   pcfl_token_type             tok_a_ff;
   pcfl_token_type             tok_b_ff;
   pcfl_token_type             tok_b_in;
   logic                       test_a_ff;
   logic signed [2*COORD_W+1:0] prod_ff [8];
   logic signed [2*COORD_W+1:0] prod_in [8];

   logic signed [COORD_W-1:0] cx, cy, dx, dy;
   logic signed [COORD_W:0]   abx, aby, acx, acy, adx, ady;
   logic signed [COORD_W:0]   cdx, cdy, cax, cay, cbx, cby;
   logic signed [2*COORD_W+2:0] s1, s2, t1, t2;
   logic                      s_ok, t_ok, hit;

   always_comb begin
      cx  = tape_ff[15:0];
      cy  = tape_ff[31:16];
      dx  = tape_ff[47:32];
      dy  = tape_ff[63:48];
      abx = 17'(tok_i.bx) - 17'(tok_i.ax);
      aby = 17'(tok_i.by) - 17'(tok_i.ay);
      acx = 17'(cx) - 17'(tok_i.ax);
      acy = 17'(cy) - 17'(tok_i.ay);
      adx = 17'(dx) - 17'(tok_i.ax);
      ady = 17'(dy) - 17'(tok_i.ay);
      cdx = 17'(dx) - 17'(cx);
      cdy = 17'(dy) - 17'(cy);
      cax = 17'(tok_i.ax) - 17'(cx);
      cay = 17'(tok_i.ay) - 17'(cy);
      cbx = 17'(tok_i.bx) - 17'(cx);
      cby = 17'(tok_i.by) - 17'(cy);
      prod_in[0] = 34'(abx) * 34'(acy);
      prod_in[1] = 34'(aby) * 34'(acx);
      prod_in[2] = 34'(abx) * 34'(ady);
      prod_in[3] = 34'(aby) * 34'(adx);
      prod_in[4] = 34'(cdx) * 34'(cay);
      prod_in[5] = 34'(cdy) * 34'(cax);
      prod_in[6] = 34'(cdx) * 34'(cby);
      prod_in[7] = 34'(cdy) * 34'(cbx);
   end

   always_comb begin
      s1 = 35'(prod_ff[0]) - 35'(prod_ff[1]);
      s2 = 35'(prod_ff[2]) - 35'(prod_ff[3]);
      t1 = 35'(prod_ff[4]) - 35'(prod_ff[5]);
      t2 = 35'(prod_ff[6]) - 35'(prod_ff[7]);
      s_ok = !((s1 > 0 && s2 > 0) || (s1 < 0 && s2 < 0));
      t_ok = !((t1 > 0 && t2 > 0) || (t1 < 0 && t2 < 0));
      hit  = s_ok && t_ok && (t1 != 0);
      tok_b_in = tok_a_ff;
      if (tok_a_ff.valid && test_a_ff && hit) begin
         tok_b_in.found = 1'b1;
         tok_b_in.hit   = HIT_W'(INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tape_ff   <= TAPE_RESET[INDEX];
         enable_ff <= ENABLE_RESET[INDEX];
      end else begin
         if (csr.we && csr.index == MY_INDEX) begin
            tape_ff <= csr.wdata;
         end
         if (csr.we && csr.index == CSR_ENABLE) begin
            enable_ff <= csr.wdata[INDEX];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_a_ff  <= '0;
         tok_b_ff  <= '0;
         test_a_ff <= 1'b0;
      end else if (advance) begin
         tok_a_ff  <= tok_i;
         tok_b_ff  <= tok_b_in;
         test_a_ff <= enable_ff && !tok_i.found;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   assign tok_o = tok_b_ff;

endmodule

/* src/pcfl_checker.sv */
// Port level checker for the finish line crossing detector, bound to the top.
// Depends on pcfl_pkg and the assertion macro header.
`include "path_crosses_finish_line_top_assert.svh"

module pcfl_checker import pcfl_pkg::*; #(
   parameter int NUM_TAPES = NUM_TAPES_DEFAULT
) (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [HIT_W-1:0]   rsp_tape_hit,
   input logic [STAMP_W-1:0] rsp_cross_time
);

   localparam int CELLS = (NUM_TAPES < TAPE_REGS) ? NUM_TAPES : TAPE_REGS;
   localparam logic [HIT_W:0] HIT_LIMIT = (HIT_W+1)'(CELLS);

   // After reset the block is empty and ready for a sample.
   `PCFL_ASSERT_NEXT(a_reset_idle, 1'b0, reset, !rsp_valid && req_ready, "not idle after reset")
   // A response only appears at the end of a segment walk, while requests are held off.
   `PCFL_ASSERT_NOW(a_rsp_from_walk, reset, $rose(rsp_valid), $past(!req_ready), "response without walk")
   // A reported tape is one that the chain actually tests.
   `PCFL_ASSERT_NOW(a_hit_range, reset, rsp_valid, {1'b0, rsp_tape_hit} < HIT_LIMIT, "tape index out of range")
   // A stalled response transaction keeps its contents.
   `PCFL_ASSERT_NEXT(a_rsp_hold, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_tape_hit) && $stable(rsp_cross_time), "stalled response changed")

endmodule

bind path_crosses_finish_line_top pcfl_checker #(.NUM_TAPES(NUM_TAPES)) u_pcfl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_tape_hit   (rsp_chan.tape_hit),
   .rsp_cross_time (rsp_chan.cross_time)
);

/* test/path_crosses_finish_line_top_tb.sv */
// Self-checking testbench for the finish line crossing detector top level.
// Drives sample transactions and CSR writes, predicts crossings with its own
// cross-product model and checks every response. Depends on pcfl_pkg and pcfl_if.
module path_crosses_finish_line_top_tb;
   import pcfl_pkg::*;

   localparam int TAPE_COUNT  = NUM_TAPES_DEFAULT;
   localparam int CHAIN_PAD   = 2 * TAPE_COUNT + 4;
   localparam int DRAIN_LIMIT = 2000;

   typedef struct {
      logic [HIT_W-1:0]   tape;
      logic [STAMP_W-1:0] stamp;
   } crossing_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   pcfl_req_if req_if ();
   pcfl_rsp_if rsp_if ();

   path_crosses_finish_line_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [CSR_DATA_W-1:0]     tape_model [TAPE_REGS];
   logic [TAPE_REGS-1:0]      enable_model;
   logic signed [COORD_W-1:0] last_x;
   logic signed [COORD_W-1:0] last_y;
   bit                        seen_first;

   crossing_type expected_crossings [$];
   int        mismatch_count = 0;
   bit        no_gaps = 1'b0;
   int        rsp_hold = 0;
   int        walk_x = 0;
   int        walk_y = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int sign_of(input longint v);
      if (v > 0) return 1;
      if (v < 0) return -1;
      return 0;
   endfunction

   function automatic bit tape_crossed(input logic signed [COORD_W-1:0] ax16, ay16, bx16, by16,
                                       input logic [CSR_DATA_W-1:0] tape);
      longint ax, ay, bx, by, cx, cy, dx, dy, s1, s2, t1, t2;
      ax = ax16;
      ay = ay16;
      bx = bx16;
      by = by16;
      cx = $signed(tape[15:0]);
      cy = $signed(tape[31:16]);
      dx = $signed(tape[47:32]);
      dy = $signed(tape[63:48]);
      s1 = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
      s2 = (bx - ax) * (dy - ay) - (by - ay) * (dx - ax);
      t1 = (dx - cx) * (ay - cy) - (dy - cy) * (ax - cx);
      t2 = (dx - cx) * (by - cy) - (dy - cy) * (bx - cx);
      return sign_of(s1) * sign_of(s2) <= 0 && sign_of(t1) * sign_of(t2) <= 0 && t1 != 0;
   endfunction

   function automatic void track_sample(input logic signed [COORD_W-1:0] x, y,
                                        input logic [STAMP_W-1:0] stamp);
      crossing_type c;
      if (!seen_first) begin
         seen_first = 1'b1;
         last_x = x;
         last_y = y;
         return;
      end
      for (int i = 0; i < TAPE_COUNT && i < TAPE_REGS; i++) begin
         if (enable_model[i] && tape_crossed(last_x, last_y, x, y, tape_model[i])) begin
            c.tape  = HIT_W'(i);
            c.stamp = stamp;
            expected_crossings.push_back(c);
            break;
         end
      end
      last_x = x;
      last_y = y;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic send_sample(input logic signed [COORD_W-1:0] x, y,
                              input logic [STAMP_W-1:0] stamp);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.pos_x    <= x;
      req_if.pos_y    <= y;
      req_if.stamp_ns <= stamp;
      do @(posedge clock); while (!req_if.ready);
      track_sample(x, y, stamp);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx < TAPE_REGS) tape_model[idx[1:0]] = data;
      else if (idx == CSR_ENABLE) enable_model = data[TAPE_REGS-1:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      int waited;
      waited = 0;
      req_if.valid <= 1'b0;
      while (expected_crossings.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_crossings.size() != 0) begin
         report_mismatch($sformatf("%0d crossings never arrived", expected_crossings.size()));
         expected_crossings.delete();
      end
      repeat (CHAIN_PAD) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         rsp_hold <= pick_gap();
      end
   end

   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_crossings.size() == 0) begin
            report_mismatch($sformatf("unexpected crossing tape %0d time %0h",
                                      rsp_if.tape_hit, rsp_if.cross_time));
         end else begin
            want = expected_crossings.pop_front();
            if (rsp_if.tape_hit !== want.tape)
               report_mismatch($sformatf("tape_hit got %0d want %0d",
                                         rsp_if.tape_hit, want.tape));
            if (rsp_if.cross_time !== want.stamp)
               report_mismatch($sformatf("cross_time got %0h want %0h",
                                         rsp_if.cross_time, want.stamp));
         end
      end
   end

   function automatic int rand_coord(input int span);
      if (span >= 32767) return int'($urandom_range(0, 65535)) - 32768;
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic [COORD_W-1:0] extreme_coord();
      case ($urandom_range(0, 3))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_tape(input int span);
      return {16'(rand_coord(span)), 16'(rand_coord(span)),
              16'(rand_coord(span)), 16'(rand_coord(span))};
   endfunction

   task automatic load_tapes(input int span, input logic [TAPE_REGS-1:0] enable);
      logic [CSR_DATA_W-1:0] mask;
      settle();
      for (int i = 0; i < TAPE_REGS; i++)
         write_reg(CSR_INDEX_W'(CSR_TAPE0 + i), rand_tape(span));
      mask = {$urandom, $urandom};
      mask[TAPE_REGS-1:0] = enable;
      write_reg(CSR_ENABLE, mask);
   endtask

   task automatic random_phase(input int count, input int span);
      int step, nx, ny;
      step = (span / 3 > 1) ? span / 3 : 1;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) settle();
         if ($urandom_range(0, 3) == 0) begin
            nx = rand_coord(32767);
            ny = rand_coord(32767);
         end else begin
            nx = walk_x + int'($urandom_range(0, 2 * step)) - step;
            ny = walk_y + int'($urandom_range(0, 2 * step)) - step;
            if (nx > span) nx = span;
            if (nx < -span) nx = -span;
            if (ny > span) ny = span;
            if (ny < -span) ny = -span;
         end
         walk_x = nx;
         walk_y = ny;
         send_sample(16'(nx), 16'(ny), {$urandom, $urandom});
      end
   endtask

   // The reset tape runs from (0,0) to (0,1.0); this exercises touching and collinear paths.
   task automatic test_reset_tape();
      send_sample(-16'sd256, 16'sd128, 64'h0);
      send_sample(16'sd256, 16'sd128, 64'hFFFF_FFFF_FFFF_FFFF);
      send_sample(16'sd256, 16'sd512, 64'h1);
      send_sample(-16'sd256, 16'sd512, 64'h2);
      send_sample(-16'sd256, 16'sd256, 64'h3);
      send_sample(16'sd256, 16'sd256, 64'h4);
      send_sample(16'sd0, 16'sd128, 64'h8000_0000_0000_0000);
      send_sample(-16'sd256, 16'sd128, 64'h5);
      send_sample(16'sd0, -16'sd256, 64'h6);
      send_sample(16'sd0, 16'sd512, 64'h7);
   endtask

   task automatic test_tape_registers();
      settle();
      for (int k = CSR_ENABLE + 1; k < 2 ** CSR_INDEX_W; k++)
         write_reg(CSR_INDEX_W'(k), {$urandom, $urandom});
      write_reg(CSR_ENABLE, 64'hFFFF_FFFF_FFFF_FFF0);
      send_sample(16'sd100, 16'sd100, 64'h10);
      send_sample(-16'sd100, -16'sd100, 64'h11);
      settle();
      write_reg(CSR_TAPE0, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_TAPE1, {16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000});
      write_reg(CSR_TAPE2, {16'h0000, 16'h7FFF, 16'h0000, 16'h8000});
      write_reg(CSR_TAPE3, {16'h7FFF, 16'h0000, 16'h8000, 16'h0000});
      write_reg(CSR_ENABLE, 64'hF);
      send_sample(-16'sd32768, -16'sd32768, 64'h20);
      send_sample(16'sd32767, 16'sd32767, 64'h21);
      send_sample(16'sd32767, -16'sd32768, 64'h22);
      send_sample(-16'sd32768, 16'sd32767, 64'h23);
      settle();
      write_reg(CSR_ENABLE, 64'hC);
      send_sample(-16'sd100, -16'sd100, 64'h30);
      send_sample(16'sd100, 16'sd100, 64'h31);
      settle();
      write_reg(CSR_ENABLE, 64'h8);
      send_sample(-16'sd100, -16'sd100, 64'h32);
   endtask

   task automatic test_random_tracks();
      load_tapes(6000, 4'hF);
      random_phase(110, 8000);

      load_tapes(32767, 4'($urandom));
      random_phase(100, 32767);

      load_tapes(4000, 4'hA);
      no_gaps = 1'b1;
      random_phase(110, 5000);
      no_gaps = 1'b0;

      load_tapes(4000, 4'h0);
      random_phase(40, 5000);

      load_tapes(3000, 4'hF);
      write_reg(CSR_TAPE1, {2{$urandom}});
      random_phase(110, 4000);

      settle();
      for (int i = 0; i < TAPE_REGS; i++)
         write_reg(CSR_INDEX_W'(CSR_TAPE0 + i), {extreme_coord(), extreme_coord(),
                                                 extreme_coord(), extreme_coord()});
      write_reg(CSR_ENABLE, 64'hF);
      random_phase(110, 32767);
   endtask

   initial begin
      req_if.valid    <= 1'b0;
      req_if.pos_x    <= '0;
      req_if.pos_y    <= '0;
      req_if.stamp_ns <= '0;
      csr_we          <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      for (int i = 0; i < TAPE_REGS; i++) tape_model[i] = TAPE_RESET[i];
      enable_model = ENABLE_RESET;
      last_x = '0;
      last_y = '0;
      seen_first = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_tape();
      test_tape_registers();
      test_random_tracks();

      settle();
      if (mismatch_count == 0) begin
         $display("path_crosses_finish_line_top_tb passed");
      end else begin
         $display("path_crosses_finish_line_top_tb failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("path_crosses_finish_line_top_tb failed");
      $finish;
   end

endmodule
